// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define GLS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
// Checks that a condition leads to a result in the next cycle.
`define GLS_ASSERT_NEXT(lbl, ante, cons) \
    `GLS_ASSERT(lbl, (ante) |=> (cons))
`else
`define GLS_ASSERT(lbl, prop)
`define GLS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/gls_pkg.sv =====
// Package with widths, register indexes and word types of the Laplacian stencil.
package gls_pkg;

    localparam int SAMPLE_WIDTH       = 16;
    localparam int LAP_WIDTH          = SAMPLE_WIDTH + 3;
    localparam int ROW_COUNT_WIDTH    = 16;
    localparam int ROW_LENGTH_WIDTH   = 11;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH     = 16;
    localparam int DEF_MAX_ROW_LENGTH = 1024;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_LENGTH = 2'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef struct packed {
        logic                           cmd;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [LAP_WIDTH-1:0] laplacian;
        logic                        frame_last;
    } t_out_word;

endpackage

// ===== design/gls_ram.sv =====
// Generic RAM with one write port and two registered read ports (read before write).
module gls_ram
    import gls_pkg::*;
#(
    parameter int WIDTH = SAMPLE_WIDTH,
    parameter int DEPTH = DEF_MAX_ROW_LENGTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/grid_laplacian_stencil_top.sv =====
// Top level of the streaming five-point Laplacian stencil over a raster grid.
//
//  Channel | Direction | Handshake                   | Word
//  --------+-----------+-----------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_in_word (cmd, sample)
//  out     | output    | o_out_valid / i_out_stall   | o_out_word (laplacian, frame_last)
//  cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One word is taken every cycle while o_in_stall is low; each word is registered in the middle
// stage and its result, if any, in the output register. The rate is set by the two row buffers,
// each read at two addresses and written at one per cycle, and by the two-register window that
// slides along the previous row. Reset is synchronous and active low; the row buffers hold no
// reset value and need no clearing pass, so words are taken in the first cycle after reset.
// A stalled output holds its word while the middle stage can still take one more
// input word; only when both are full does the input see a stall.
module grid_laplacian_stencil_top
    import gls_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  t_in_word                   i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output t_out_word                  o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

`include "assert_macros.svh"

    // Column counter width and a compare width that holds both the row length
    // register and the buffer depth.
    localparam int CW   = $clog2(MAX_ROW_LENGTH);
    localparam int CMPW = ((CW > ROW_LENGTH_WIDTH) ? CW : ROW_LENGTH_WIDTH) + 1;

    // Item information carried from acceptance to the window stage.
    typedef struct packed {
        logic                           has_result;
        logic                           drain;
        logic                           frame_last;
        logic                           first_col;
        logic                           row_end;
        logic                           up_ok;
        logic                           bsel;
        logic                           bypass;
        logic signed [SAMPLE_WIDTH-1:0] sample;
    } t_s1;

    // Configuration registers.
    logic [ROW_COUNT_WIDTH-1:0]  r_row_count;
    logic [ROW_LENGTH_WIDTH-1:0] r_row_length;

    // Frame position.
    logic [ROW_COUNT_WIDTH-1:0]  r_row;
    logic [CW-1:0]               r_col;
    logic                        r_bsel;

    // Pipeline registers.
    logic                        r_s1_valid;
    t_s1                         r_s1;
    logic                        r_out_valid;
    t_out_word                   r_out;

    // Sliding window over the previous row: column c-1 and column c.
    logic signed [SAMPLE_WIDTH-1:0] r_left;
    logic signed [SAMPLE_WIDTH-1:0] r_cen;

    logic [ROW_COUNT_WIDTH-1:0] rows_eff;
    logic [CMPW-1:0]            len_raw;
    logic [CMPW-1:0]            len_eff;
    logic [CMPW-1:0]            col_next_ext;
    logic                       drain;
    logic                       row_end;
    logic                       ignore;
    logic                       accept;
    logic                       active;
    logic                       out_load;
    logic                       s1_adv;
    logic                       s1_load;
    logic [CW-1:0]              raddr_b;
    logic [SAMPLE_WIDTH-1:0]    older_a;
    logic [SAMPLE_WIDTH-1:0]    older_b;
    logic [SAMPLE_WIDTH-1:0]    newer_a;
    logic [SAMPLE_WIDTH-1:0]    newer_b;
    logic signed [SAMPLE_WIDTH-1:0] up_raw;
    logic signed [SAMPLE_WIDTH-1:0] next_raw;
    logic signed [SAMPLE_WIDTH-1:0] next_val;
    logic signed [LAP_WIDTH-1:0]    lap_center;
    logic signed [LAP_WIDTH-1:0]    lap_left;
    logic signed [LAP_WIDTH-1:0]    lap_right;
    logic signed [LAP_WIDTH-1:0]    lap_up;
    logic signed [LAP_WIDTH-1:0]    lap_down;
    logic signed [LAP_WIDTH-1:0]    lap_sum;
    t_s1                            n_s1;

    assign o_cfg_ready = 1'b1;

    // Register limits as the datapath sees them: zero acts as one, and a row
    // longer than the buffers acts as the buffer depth.
    always_comb begin
        rows_eff     = (r_row_count == '0) ? ROW_COUNT_WIDTH'(1) : r_row_count;
        len_raw      = (r_row_length == '0) ? CMPW'(1) : CMPW'(r_row_length);
        len_eff      = (len_raw > CMPW'(MAX_ROW_LENGTH)) ? CMPW'(MAX_ROW_LENGTH) : len_raw;
        col_next_ext = CMPW'(r_col) + CMPW'(1);
        drain        = (r_row >= rows_eff);
        row_end      = (col_next_ext >= len_eff);
        // A drain word that arrives before the frame is complete is dropped.
        ignore       = !drain && (i_in_word.cmd == CMD_DRAIN);
    end

    // Handshake: the output register loads when empty or taken, the middle
    // stage moves on when its item needs no output slot or one is free.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && (out_load || !r_s1.has_result);
    assign s1_load    = !r_s1_valid || s1_adv;
    assign o_in_stall = !s1_load;
    assign accept     = i_in_valid && s1_load;
    assign active     = accept && !ignore;

    // Port b fetches the right neighbor; at a row end it fetches column zero
    // of the row just finished, which becomes the center of the next row.
    assign raddr_b = row_end ? '0 : (r_col + CW'(1));

    gls_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_older_row (
        .i_clk     (i_clk),
        .i_we      (active && !drain && !r_bsel),
        .i_waddr   (r_col),
        .i_wdata   (i_in_word.sample),
        .i_re      (active),
        .i_raddr_a (r_col),
        .i_raddr_b (raddr_b),
        .o_rdata_a (older_a),
        .o_rdata_b (older_b)
    );

    gls_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_newer_row (
        .i_clk     (i_clk),
        .i_we      (active && !drain && r_bsel),
        .i_waddr   (r_col),
        .i_wdata   (i_in_word.sample),
        .i_re      (active),
        .i_raddr_a (r_col),
        .i_raddr_b (raddr_b),
        .o_rdata_a (newer_a),
        .o_rdata_b (newer_b)
    );

    always_comb begin
        n_s1.has_result = drain || (r_row != '0);
        n_s1.drain      = drain;
        n_s1.frame_last = drain && row_end;
        n_s1.first_col  = (r_col == '0);
        n_s1.row_end    = row_end;
        n_s1.up_ok      = (r_row >= ROW_COUNT_WIDTH'(2));
        n_s1.bsel       = r_bsel;
        // With a one-column row, column zero is read while it is written.
        n_s1.bypass     = row_end && !drain && (r_col == '0);
        n_s1.sample     = i_in_word.sample;
    end

    // Configuration and frame position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= ROW_COUNT_WIDTH'(1);
            r_row_length <= ROW_LENGTH_WIDTH'(1);
            r_row        <= '0;
            r_col        <= '0;
            r_bsel       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_ROW_COUNT: begin
                        r_row_count <= i_cfg_data[ROW_COUNT_WIDTH-1:0];
                    end
                    REG_ROW_LENGTH: begin
                        r_row_length <= i_cfg_data[ROW_LENGTH_WIDTH-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (active) begin
                priority if (drain && row_end) begin
                    // Last cell of the frame: start over for the next frame.
                    r_row  <= '0;
                    r_col  <= '0;
                    r_bsel <= 1'b0;
                end else if (drain) begin
                    r_col <= r_col + CW'(1);
                end else if (row_end) begin
                    r_col  <= '0;
                    r_row  <= r_row + ROW_COUNT_WIDTH'(1);
                    r_bsel <= !r_bsel;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // Middle stage: the row buffer outputs are registered inside the RAMs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (active) begin
            r_s1 <= n_s1;
        end
    end

    // The writing buffer is the newer one when the select bit is set.
    always_comb begin
        up_raw   = r_s1.bsel ? newer_a : older_a;
        if (r_s1.row_end ? r_s1.bsel : !r_s1.bsel) begin
            next_raw = newer_b;
        end else begin
            next_raw = older_b;
        end
        next_val = r_s1.bypass ? r_s1.sample : next_raw;

        lap_center = LAP_WIDTH'(r_cen);
        lap_left   = r_s1.first_col ? lap_center : LAP_WIDTH'(r_left);
        lap_right  = r_s1.row_end ? lap_center : LAP_WIDTH'(next_raw);
        lap_up     = r_s1.up_ok ? LAP_WIDTH'(up_raw) : lap_center;
        lap_down   = r_s1.drain ? lap_center : LAP_WIDTH'(r_s1.sample);
        lap_sum    = lap_left + lap_right + lap_up + lap_down - (lap_center <<< 2);
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_left <= r_cen;
            r_cen  <= next_val;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid && r_s1.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid && r_s1.has_result) begin
            r_out.laplacian  <= lap_sum;
            r_out.frame_last <= r_s1.frame_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // The input sees a stall only when both pipeline stages are held.
    `GLS_ASSERT(a_stall_only_when_full, o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
    // The last cell of a frame returns the frame position to its start.
    `GLS_ASSERT_NEXT(a_frame_restart, active && drain && row_end, (r_row == '0) && (r_col == '0) && !r_bsel)
    // Finishing a received row swaps the roles of the two buffers.
    `GLS_ASSERT_NEXT(a_buffer_swap, active && !drain && row_end, r_bsel != $past(r_bsel))

endmodule
